FILE: src/hsvsc_pkg.sv
// Shared types and constants of the HSV skin colour classifier.
`timescale 1ns / 1ps

package hsvsc_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_W     = 9;
    localparam int SAT_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam int BASE_W    = 11;
    localparam int HPROD_W   = 17;
    localparam int SPROD_W   = 15;

    localparam logic [HPROD_W-1:0] HUE_SCALE = HPROD_W'(60);
    localparam logic [SPROD_W-1:0] PCT_SCALE = SPROD_W'(100);

    localparam logic [HUE_W-1:0]  HUE_LOW_RST  = HUE_W'(0);
    localparam logic [HUE_W-1:0]  HUE_HIGH_RST = HUE_W'(50);
    localparam logic [SAT_W-1:0]  SAT_LOW_RST  = SAT_W'(23);
    localparam logic [SAT_W-1:0]  SAT_HIGH_RST = SAT_W'(68);
    localparam logic [CHAN_W-1:0] FILL_RST     = CHAN_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW  = 3'd0,
        CFG_HUE_HIGH = 3'd1,
        CFG_SAT_LOW  = 3'd2,
        CFG_SAT_HIGH = 3'd3,
        CFG_FILL     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_low;
        logic [HUE_W-1:0]  hue_high;
        logic [SAT_W-1:0]  sat_low;
        logic [SAT_W-1:0]  sat_high;
        logic [CHAN_W-1:0] fill;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t pix;
        logic   skin;
    } class_item_t;

endpackage

FILE: src/hsvsc_if.sv
// Channel interfaces of the HSV skin colour classifier.
`timescale 1ns / 1ps

interface hsvsc_in_if import hsvsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface hsvsc_out_if import hsvsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              skin_flag;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output skin_flag, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input skin_flag, output ready);
endinterface

interface hsvsc_cfg_if import hsvsc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/hsvsc_front.sv
// Front pipeline: spread and hue numerator, bound products, skin decision.
`timescale 1ns / 1ps

module hsvsc_front import hsvsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  pixel_t      in_pix,
    output logic        push_valid,
    input  logic        push_ready,
    output class_item_t push_item
);

    logic [CHAN_W-1:0] vmax;
    logic [CHAN_W-1:0] vmin;
    logic [CHAN_W-1:0] spread;
    logic [BASE_W-1:0] base;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    pixel_t            s1_pix_reg;
    logic [CHAN_W-1:0] s1_vmax_reg;
    logic [CHAN_W-1:0] s1_spread_reg;
    logic [BASE_W-1:0] s1_base_reg;
    logic              s1_grey_reg;

    logic               s2_valid_reg;
    logic               s2_valid_next;
    pixel_t             s2_pix_reg;
    logic               s2_grey_reg;
    logic [HPROD_W-1:0] s2_num_reg;
    logic [HPROD_W-1:0] s2_hlo_reg;
    logic [HPROD_W-1:0] s2_hhi_reg;
    logic [SPROD_W-1:0] s2_pct_reg;
    logic [SPROD_W-1:0] s2_slo_reg;
    logic [SPROD_W-1:0] s2_shi_reg;

    logic adv2;
    logic adv1;

    always_comb
    begin
        vmax = in_pix.red;
        vmin = in_pix.red;
        if (in_pix.green > vmax) vmax = in_pix.green;
        if (in_pix.blue > vmax)  vmax = in_pix.blue;
        if (in_pix.green < vmin) vmin = in_pix.green;
        if (in_pix.blue < vmin)  vmin = in_pix.blue;
        spread = vmax - vmin;

        if (in_pix.blue == vmax)
            base = (BASE_W'(spread) << 2) + BASE_W'(in_pix.red) - BASE_W'(in_pix.green);
        else if (in_pix.green == vmax)
            base = (BASE_W'(spread) << 1) + BASE_W'(in_pix.blue) - BASE_W'(in_pix.red);
        else if (in_pix.green >= in_pix.blue)
            base = BASE_W'(in_pix.green) - BASE_W'(in_pix.blue);
        else
            base = (BASE_W'(spread) << 2) + (BASE_W'(spread) << 1)
                 + BASE_W'(in_pix.green) - BASE_W'(in_pix.blue);
    end

    assign adv2          = !s2_valid_reg || push_ready;
    assign adv1          = !s1_valid_reg || adv2;
    assign in_ready      = adv1;
    assign s1_valid_next = adv1 ? in_valid : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_pix_reg    <= in_pix;
            s1_vmax_reg   <= vmax;
            s1_spread_reg <= spread;
            s1_base_reg   <= base;
            s1_grey_reg   <= (spread == '0);
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_pix_reg  <= s1_pix_reg;
            s2_grey_reg <= s1_grey_reg;
            s2_num_reg  <= HPROD_W'(s1_base_reg) * HUE_SCALE;
            s2_hlo_reg  <= HPROD_W'(cfg.hue_low) * HPROD_W'(s1_spread_reg);
            s2_hhi_reg  <= HPROD_W'(cfg.hue_high) * HPROD_W'(s1_spread_reg);
            s2_pct_reg  <= SPROD_W'(s1_spread_reg) * PCT_SCALE;
            s2_slo_reg  <= SPROD_W'(cfg.sat_low) * SPROD_W'(s1_vmax_reg);
            s2_shi_reg  <= SPROD_W'(cfg.sat_high) * SPROD_W'(s1_vmax_reg);
        end
    end

    assign push_valid     = s2_valid_reg;
    assign push_item.pix  = s2_pix_reg;
    assign push_item.skin = !s2_grey_reg
                          && (s2_num_reg >= s2_hlo_reg) && (s2_num_reg <= s2_hhi_reg)
                          && (s2_pct_reg >= s2_slo_reg) && (s2_pct_reg <= s2_shi_reg);

endmodule

FILE: src/hsvsc_queue.sv
// Two-entry queue between the classifying front and the output back end.
`timescale 1ns / 1ps

module hsvsc_queue import hsvsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  class_item_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output class_item_t pop_item
);

    class_item_t slot0_reg;
    class_item_t slot1_reg;
    logic        wr_sel_reg;
    logic        wr_sel_next;
    logic        rd_sel_reg;
    logic        rd_sel_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = rd_sel_reg ? slot1_reg : slot0_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_sel_next = push ? !wr_sel_reg : wr_sel_reg;
        rd_sel_next = pop ? !rd_sel_reg : rd_sel_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !wr_sel_reg)
            slot0_reg <= push_item;
        if (push && wr_sel_reg)
            slot1_reg <= push_item;
    end

endmodule

FILE: src/hsvsc_back.sv
// Back end: substitute the fill level for rejected pixels and hold the result.
`timescale 1ns / 1ps

module hsvsc_back import hsvsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [CHAN_W-1:0] fill,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  class_item_t pop_item,
    output logic        out_valid,
    input  logic        out_ready,
    output pixel_t      out_pix,
    output logic        out_skin
);

    logic   valid_reg;
    logic   valid_next;
    pixel_t pix_reg;
    pixel_t pix_next;
    logic   skin_reg;
    logic   load;

    assign pop_ready  = !valid_reg || out_ready;
    assign load       = pop_valid && pop_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_comb
    begin
        if (pop_item.skin)
            pix_next = pop_item.pix;
        else
        begin
            pix_next.red   = fill;
            pix_next.green = fill;
            pix_next.blue  = fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= pix_next;
            skin_reg <= pop_item.skin;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;
    assign out_skin  = skin_reg;

endmodule

FILE: src/hsv_skin_color_classifier.sv
// Top level of the HSV skin colour classifier: settings registers and datapath.
// Throughput: one pixel per cycle while the output accepts; stalls fill a two-entry queue.
// Path: an input passes two front pipeline stages, one queue entry and the output register.
// Reset: empties the pipeline and queue and returns the bounds and fill level to defaults.
`timescale 1ns / 1ps

module hsv_skin_color_classifier import hsvsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hsvsc_in_if.sink     pixel,
    hsvsc_out_if.source  result,
    hsvsc_cfg_if.sink    cfg
);

    logic [HUE_W-1:0]  hue_low_reg;
    logic [HUE_W-1:0]  hue_high_reg;
    logic [SAT_W-1:0]  sat_low_reg;
    logic [SAT_W-1:0]  sat_high_reg;
    logic [CHAN_W-1:0] fill_reg;
    cfg_t              cfg_cur;

    pixel_t      in_pix;
    logic        push_valid;
    logic        push_ready;
    class_item_t push_item;
    logic        pop_valid;
    logic        pop_ready;
    class_item_t pop_item;
    pixel_t      out_pix;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= HUE_LOW_RST;
            hue_high_reg <= HUE_HIGH_RST;
            sat_low_reg  <= SAT_LOW_RST;
            sat_high_reg <= SAT_HIGH_RST;
            fill_reg     <= FILL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_HUE_LOW:  hue_low_reg  <= cfg.data[HUE_W-1:0];
                CFG_HUE_HIGH: hue_high_reg <= cfg.data[HUE_W-1:0];
                CFG_SAT_LOW:  sat_low_reg  <= cfg.data[SAT_W-1:0];
                CFG_SAT_HIGH: sat_high_reg <= cfg.data[SAT_W-1:0];
                CFG_FILL:     fill_reg     <= cfg.data[CHAN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg_cur.hue_low  = hue_low_reg;
    assign cfg_cur.hue_high = hue_high_reg;
    assign cfg_cur.sat_low  = sat_low_reg;
    assign cfg_cur.sat_high = sat_high_reg;
    assign cfg_cur.fill     = fill_reg;

    assign in_pix.red   = pixel.red_in;
    assign in_pix.green = pixel.green_in;
    assign in_pix.blue  = pixel.blue_in;

    hsvsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_cur),
        .in_valid   (pixel.valid),
        .in_ready   (pixel.ready),
        .in_pix     (in_pix),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    hsvsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    hsvsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fill       (cfg_cur.fill),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_pix    (out_pix),
        .out_skin   (result.skin_flag)
    );

    assign result.red_out   = out_pix.red;
    assign result.green_out = out_pix.green;
    assign result.blue_out  = out_pix.blue;

endmodule

FILE: sim/tb_hsv_skin_color_classifier.sv
// Self-checking testbench for the HSV skin colour classifier.
`timescale 1ns / 1ps

module tb_hsv_skin_color_classifier;
    import hsvsc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_PIXELS = 170;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    class skin_checker;
        class_item_t       expected_pixels[$];
        logic [HUE_W-1:0]  hue_lo;
        logic [HUE_W-1:0]  hue_hi;
        logic [SAT_W-1:0]  sat_lo;
        logic [SAT_W-1:0]  sat_hi;
        logic [CHAN_W-1:0] fill;
        int                n_pixels;
        int                n_skin;
        int                n_checked;
        int                n_mismatch;

        function new();
            hue_lo     = HUE_LOW_RST;
            hue_hi     = HUE_HIGH_RST;
            sat_lo     = SAT_LOW_RST;
            sat_hi     = SAT_HIGH_RST;
            fill       = FILL_RST;
            n_pixels   = 0;
            n_skin     = 0;
            n_checked  = 0;
            n_mismatch = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_HUE_LOW:  hue_lo = val[HUE_W-1:0];
                CFG_HUE_HIGH: hue_hi = val[HUE_W-1:0];
                CFG_SAT_LOW:  sat_lo = val[SAT_W-1:0];
                CFG_SAT_HIGH: sat_hi = val[SAT_W-1:0];
                CFG_FILL:     fill   = val[CHAN_W-1:0];
                default:      ;
            endcase
        endfunction

        function class_item_t classify_pixel(pixel_t p);
            class_item_t res;
            int          r;
            int          g;
            int          b;
            int          vmax;
            int          vmin;
            int          d;
            int          diff;
            int          k;
            int          num;
            bit          skin;
            r    = int'(p.red);
            g    = int'(p.green);
            b    = int'(p.blue);
            vmax = r;
            vmin = r;
            if (g > vmax) vmax = g;
            if (b > vmax) vmax = b;
            if (g < vmin) vmin = g;
            if (b < vmin) vmin = b;
            d    = vmax - vmin;
            // blue wins ties, then green
            if (b == vmax)
            begin
                k    = 4;
                diff = r - g;
            end
            else if (g == vmax)
            begin
                k    = 2;
                diff = b - r;
            end
            else
            begin
                diff = g - b;
                k    = (diff < 0) ? 6 : 0;
            end
            num  = 60 * (k * d + diff);
            skin = (d != 0)
                && (num >= int'(hue_lo) * d) && (num <= int'(hue_hi) * d)
                && (100 * d >= int'(sat_lo) * vmax) && (100 * d <= int'(sat_hi) * vmax);
            res.skin = skin;
            if (skin)
                res.pix = p;
            else
            begin
                res.pix.red   = fill;
                res.pix.green = fill;
                res.pix.blue  = fill;
            end
            return res;
        endfunction

        function void note_pixel(pixel_t p);
            class_item_t res;
            res = classify_pixel(p);
            expected_pixels.push_back(res);
            n_pixels++;
            if (res.skin)
                n_skin++;
        endfunction

        function void check_result(class_item_t got);
            class_item_t want;
            n_checked++;
            if (expected_pixels.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("Unexpected result: r=%0d g=%0d b=%0d skin=%0d",
                             got.pix.red, got.pix.green, got.pix.blue, got.skin);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pix.red != want.pix.red || got.pix.green != want.pix.green
                || got.pix.blue != want.pix.blue || got.skin != want.skin)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display({"Mismatch: expected r=%0d g=%0d b=%0d skin=%0d,",
                              " got r=%0d g=%0d b=%0d skin=%0d"},
                             want.pix.red, want.pix.green, want.pix.blue, want.skin,
                             got.pix.red, got.pix.green, got.pix.blue, got.skin);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int          cycles;
    int          send_gap_pct;
    int          recv_stall_pct;
    int          n_settings;
    skin_checker board;

    pixel_t directed_pixels[$] = '{
        '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
        '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
        '{8'd255, 8'd0,   8'd10},  '{8'd200, 8'd150, 8'd100}, '{8'd100, 8'd77,  8'd77},
        '{8'd100, 8'd32,  8'd32},  '{8'd100, 8'd31,  8'd31},  '{8'd100, 8'd95,  8'd70},
        '{8'd100, 8'd96,  8'd70},  '{8'd1,   8'd0,   8'd0},   '{8'd255, 8'd254, 8'd254},
        '{8'd254, 8'd255, 8'd255}, '{8'd170, 8'd85,  8'd85},  '{8'd120, 8'd130, 8'd80},
        '{8'd255, 8'd170, 8'd0}
    };

    hsvsc_in_if  pixel_ch();
    hsvsc_out_if result_ch();
    hsvsc_cfg_if cfg_ch();

    hsv_skin_color_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                board.note_pixel('{red: pixel_ch.red_in, green: pixel_ch.green_in,
                                   blue: pixel_ch.blue_in});
            if (result_ch.valid && result_ch.ready)
                board.check_result('{pix: '{red: result_ch.red_out,
                                            green: result_ch.green_out,
                                            blue: result_ch.blue_out},
                                     skin: result_ch.skin_flag});
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic pixel_t make_pixel();
        pixel_t p;
        int     r;
        int     g;
        int     b;
        int     t;
        int     kind;
        kind = $urandom_range(9);
        r    = $urandom_range(255);
        g    = $urandom_range(255);
        b    = $urandom_range(255);
        if (kind >= 4 && kind <= 6)
        begin
            r = $urandom_range(255, 60);
            g = $urandom_range(r, r / 4);
            b = $urandom_range(g, g / 4);
            if (kind == 6)
            begin
                repeat ($urandom_range(2))
                begin
                    t = r;
                    r = g;
                    g = b;
                    b = t;
                end
                if ($urandom_range(1))
                begin
                    t = r;
                    r = g;
                    g = t;
                end
            end
        end
        else if (kind == 7)
        begin
            g = r;
            b = r;
        end
        else if (kind == 8)
        begin
            b = $urandom_range(r);
            case ($urandom_range(2))
                0:       g = r;
                1:       begin g = b; b = r; end
                default: begin g = b; b = r; r = g; g = b; end
            endcase
        end
        else if (kind == 9)
        begin
            r = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
            g = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
            b = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
        end
        p.red   = CHAN_W'(r);
        p.green = CHAN_W'(g);
        p.blue  = CHAN_W'(b);
        return p;
    endfunction

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SEND: begin send_gap_pct = 52; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 52; end
            IDLE_BOTH: begin send_gap_pct = 11; recv_stall_pct = 11; end
            default:   begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // enter and leave on a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_ch.valid    <= 1'b1;
        pixel_ch.red_in   <= p.red;
        pixel_ch.green_in <= p.green;
        pixel_ch.blue_in  <= p.blue;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic finish_stream();
        pixel_ch.valid <= 1'b0;
        @(negedge clk);
        while (board.expected_pixels.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_phase(idle_mode_t mode, logic [CFG_DAT_W-1:0] hue_lo,
                             logic [CFG_DAT_W-1:0] hue_hi, logic [CFG_DAT_W-1:0] sat_lo,
                             logic [CFG_DAT_W-1:0] sat_hi, logic [CFG_DAT_W-1:0] fill);
        set_idle(mode);
        write_reg(CFG_HUE_LOW,  hue_lo);
        write_reg(CFG_HUE_HIGH, hue_hi);
        write_reg(CFG_SAT_LOW,  sat_lo);
        write_reg(CFG_SAT_HIGH, sat_hi);
        write_reg(CFG_FILL,     fill);
        n_settings++;
        repeat (PHASE_PIXELS)
            send_pixel(make_pixel());
        finish_stream();
    endtask

    initial
    begin
        board             = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        cycles            = 0;
        n_settings        = 1;
        send_gap_pct      = 0;
        recv_stall_pct    = 0;
        pixel_ch.valid    = 1'b0;
        pixel_ch.red_in   = '0;
        pixel_ch.green_in = '0;
        pixel_ch.blue_in  = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idle(IDLE_NONE);
        foreach (directed_pixels[i])
            send_pixel(directed_pixels[i]);
        repeat (PHASE_PIXELS)
            send_pixel(make_pixel());
        finish_stream();

        run_phase(IDLE_SEND, 9'd0,   9'd360, 9'd0,   9'd100, 9'd0);
        run_phase(IDLE_RECV, 9'd300, 9'd359, 9'd10,  9'd90,  9'd128);
        run_phase(IDLE_BOTH, 9'd511, 9'd511, 9'd127, 9'd127, 9'd255);
        run_phase(IDLE_NONE, 9'd60,  9'd20,  9'd50,  9'd40,  CFG_DAT_W'($urandom));
        run_phase(IDLE_SEND, CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
                  CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
        run_phase(IDLE_RECV, 9'd0,   9'd0,   9'd0,   9'd100, 9'd1);
        run_phase(IDLE_BOTH, 9'd90,  9'd270, 9'd20,  9'd100, 9'h107);

        // drop writes to unused indexes
        for (int k = int'(CFG_FILL) + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), CFG_DAT_W'($urandom));
        run_phase(IDLE_NONE, CFG_DAT_W'(HUE_LOW_RST), CFG_DAT_W'(HUE_HIGH_RST),
                  CFG_DAT_W'(SAT_LOW_RST), CFG_DAT_W'(SAT_HIGH_RST), CFG_DAT_W'(FILL_RST));

        if (board.expected_pixels.size() != 0)
            board.n_mismatch++;
        $display("Classified %0d pixels under %0d register settings: %0d skin, %0d filled",
                 board.n_pixels, n_settings, board.n_skin, board.n_pixels - board.n_skin);
        $display("Checked %0d results, %0d mismatches", board.n_checked, board.n_mismatch);
        if (board.n_mismatch == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/hsvsc_pkg.sv
src/hsvsc_if.sv
src/hsvsc_front.sv
src/hsvsc_queue.sv
src/hsvsc_back.sv
src/hsv_skin_color_classifier.sv
sim/tb_hsv_skin_color_classifier.sv
